FILE: sv/strict_priority_multi_fifo_core_macros.svh
// ----------------------------------------------------------------------------
// Strict priority multi-FIFO assertion macros
// Shared concurrent check forms used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_MULTI_FIFO_CORE_MACROS_SVH
`define STRICT_PRIORITY_MULTI_FIFO_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define SPMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmf: same-cycle check failed");

// Next-cycle implication, disabled while reset is active
`define SPMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmf: next-cycle check failed");

`endif

FILE: sv/spmf_pkg.sv
// ----------------------------------------------------------------------------
// Strict priority multi-FIFO package
// Request, result and internal command types, plus opcode encodings.
// ----------------------------------------------------------------------------
package spmf_pkg;

    // Request opcodes
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_BATCH = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // Request payload
    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  priority_req;
        logic [31:0] push_value;
        logic [4:0]  batch_count;
    } t_req;

    // Result payload
    typedef struct packed {
        logic        ok;
        logic [31:0] served_value;
        logic [2:0]  served_level;
        logic        last;
        logic [7:0]  total_count;
        logic [4:0]  level_count;
    } t_result;

    // Decoded command kinds
    typedef enum logic [2:0] {
        K_PUSH,
        K_POP,
        K_PEEK,
        K_BATCH,
        K_CLEAR,
        K_BAD
    } t_kind;

    // Command passed from front end to back end
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  prio;
        logic [31:0] value;
        logic [4:0]  limit;
    } t_cmd;

endpackage

FILE: sv/strict_priority_multi_fifo_core.sv
// ----------------------------------------------------------------------------
// Strict priority multi-FIFO core
// LEVELS priority FIFOs of DEPTH values each, served highest level first.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive start with i_req; the request is taken on a rising
//   edge with start high and busy low. Opcodes are push, pop, peek, pop batch
//   and clear.
//   Result channel: o_done is high for exactly one cycle per result, with the
//   result on o_result; the receiver cannot stall it. Every request gives at
//   least one result, a batch one per value taken, with last set on the final.
//   Timing: with the back end idle, an accepted request is registered in the
//   command queue, then executed by the back end, which registers its result; a
//   batch first moves the back end to S_BATCH, then gives one value per cycle.
//   Throughput: push, pop, peek and clear run at one request per cycle while
//   no batch holds the back end, set by the back end executing one command per
//   cycle with one write port and one read port. A batch holds the back end
//   until its last value is out. A two-entry command queue sits between the
//   front and back ends; busy is high while it is full.
//   Reset (synchronous, active low) empties all levels and the queue; stored
//   values are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_core #(
    parameter int LEVELS      = 4,
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int BATCH_MAX   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spmf_pkg::t_req    i_req,
    output logic              o_done,
    output spmf_pkg::t_result o_result
);

    logic           w_cmd_valid;
    spmf_pkg::t_cmd w_cmd;
    logic           w_cmd_pop;

    // Request decode and command queue
    spmf_front #(
        .BATCH_MAX (BATCH_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Level storage and command execution
    spmf_back #(
        .LEVELS      (LEVELS),
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

FILE: sv/spmf_front.sv
// ----------------------------------------------------------------------------
// Strict priority multi-FIFO front end
// Accepts requests, decodes them into commands and buffers them in a
// two-entry queue ahead of the back end.
// ----------------------------------------------------------------------------
`include "strict_priority_multi_fifo_core_macros.svh"

module spmf_front #(
    parameter int BATCH_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spmf_pkg::t_req    i_req,
    output logic              o_cmd_valid,
    output spmf_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);

    spmf_pkg::t_cmd r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    spmf_pkg::t_cmd n_cmd;
    logic           w_acc;

    assign busy        = (r_cnt == 2'd2);
    assign w_acc       = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // Decode request into a command
    always_comb begin
        n_cmd.prio  = i_req.priority_req;
        n_cmd.value = i_req.push_value;
        n_cmd.limit = (int'(i_req.batch_count) > BATCH_MAX) ? 5'(BATCH_MAX)
                                                            : i_req.batch_count;
        unique case (i_req.opcode)
            spmf_pkg::OP_PUSH:  n_cmd.kind = spmf_pkg::K_PUSH;
            spmf_pkg::OP_POP:   n_cmd.kind = spmf_pkg::K_POP;
            spmf_pkg::OP_PEEK:  n_cmd.kind = spmf_pkg::K_PEEK;
            spmf_pkg::OP_BATCH: n_cmd.kind = spmf_pkg::K_BATCH;
            spmf_pkg::OP_CLEAR: n_cmd.kind = spmf_pkg::K_CLEAR;
            default:            n_cmd.kind = spmf_pkg::K_BAD;
        endcase
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, i_cmd_pop};
        end
    end

    `SPMF_ASSERT_NEXT(a_pop_needs_entry, i_clk, i_rst_n, (r_cnt == 2'd0 && !w_acc), !o_cmd_valid)

endmodule

FILE: sv/spmf_back.sv
// ----------------------------------------------------------------------------
// Strict priority multi-FIFO back end
// Holds the level FIFOs and their pointers and counts, executes commands and
// drives the registered result port.
// ----------------------------------------------------------------------------
`include "strict_priority_multi_fifo_core_macros.svh"

module spmf_back #(
    parameter int LEVELS      = 4,
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  spmf_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_done,
    output spmf_pkg::t_result o_result
);

    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int LW      = $clog2(LEVELS);
    localparam int PW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int TW      = $clog2(ENTRIES + 1);
    localparam int AW      = $clog2(ENTRIES);
    localparam int XW      = (TW > 5) ? TW : 5;

    typedef enum logic {
        S_IDLE,
        S_BATCH
    } t_state;

    // Level state
    logic [PW-1:0]          r_head [LEVELS];
    logic [PW-1:0]          r_tail [LEVELS];
    logic [CW-1:0]          r_cnt  [LEVELS];
    logic [TW-1:0]          r_total;
    logic [VALUE_WIDTH-1:0] r_mem  [ENTRIES];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    // Control and result registers
    t_state     r_state, n_state;
    logic       r_done, n_done;
    logic       r_ok, n_ok;
    logic       r_use_mem, n_use_mem;
    logic [2:0] r_lvl, n_lvl;
    logic       r_last, n_last;
    logic [7:0] r_tot_o, n_tot_o;
    logic [4:0] r_lc_o, n_lc_o;
    logic [4:0] r_b_left, n_b_left;
    logic [7:0] r_b_tot, n_b_tot;
    logic [4:0] r_b_lc, n_b_lc;

    // Combinational helpers
    logic [LEVELS-1:0] w_mask;
    logic              w_any;
    logic [LW-1:0]     w_top;
    logic              w_pv;
    logic [LW-1:0]     w_pi;
    logic [CW-1:0]     w_pc;
    logic [TW-1:0]     w_above;
    logic [TW-1:0]     w_sum;
    logic [XW-1:0]     w_bn;
    logic [XW-1:0]     w_rem;
    logic [CW-1:0]     w_lc_after;
    logic [TW-1:0]     w_tot_after;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;
    logic              w_push;
    logic              w_pop;
    logic              w_clear;
    logic              w_re;

    function automatic logic [PW-1:0] f_bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Occupancy mask and highest non-empty level
    always_comb begin
        w_top = '0;
        for (int i = 0; i < LEVELS; i++) begin
            w_mask[i] = (r_cnt[i] != '0);
            if (w_mask[i]) begin
                w_top = LW'(i);
            end
        end
        w_any = |w_mask;
    end

    // Requested level and counts above it
    assign w_pv = ({1'b0, i_cmd.prio} < 4'(LEVELS));
    assign w_pi = i_cmd.prio[LW-1:0];
    assign w_pc = r_cnt[w_pi];

    always_comb begin
        w_above = '0;
        w_sum   = '0;
        for (int i = 0; i < LEVELS; i++) begin
            w_sum = w_sum + TW'(r_cnt[i]);
            if (i > int'(i_cmd.prio)) begin
                w_above = w_above + TW'(r_cnt[i]);
            end
        end
    end

    // Batch size and counts left once the whole batch is drained
    always_comb begin
        w_bn  = (XW'(i_cmd.limit) < XW'(r_total)) ? XW'(i_cmd.limit) : XW'(r_total);
        w_rem = (w_bn > XW'(w_above)) ? (w_bn - XW'(w_above)) : '0;
        if (w_rem >= XW'(w_pc)) begin
            w_lc_after = '0;
        end else begin
            w_lc_after = w_pc - CW'(w_rem);
        end
        w_tot_after = r_total - TW'(w_bn);
    end

    // Memory addresses: head of the top level, tail of the requested level
    assign w_raddr = AW'(int'(w_top) * DEPTH) + AW'(r_head[w_top]);
    assign w_waddr = AW'(int'(w_pi) * DEPTH) + AW'(r_tail[w_pi]);

    // Command sequencing
    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_ok      = 1'b0;
        n_use_mem = 1'b0;
        n_lvl     = 3'd0;
        n_last    = 1'b1;
        n_tot_o   = 8'(r_total);
        n_lc_o    = w_pv ? 5'(w_pc) : 5'd0;
        n_b_left  = r_b_left;
        n_b_tot   = r_b_tot;
        n_b_lc    = r_b_lc;
        o_cmd_pop = 1'b0;
        w_push    = 1'b0;
        w_pop     = 1'b0;
        w_clear   = 1'b0;
        w_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_done    = 1'b1;
                    unique case (i_cmd.kind) inside
                        spmf_pkg::K_PUSH: begin
                            if (w_pv && w_pc != CW'(DEPTH)) begin
                                w_push  = 1'b1;
                                n_ok    = 1'b1;
                                n_tot_o = 8'(r_total + TW'(1));
                                n_lc_o  = 5'(w_pc + CW'(1));
                            end
                        end
                        spmf_pkg::K_POP, spmf_pkg::K_PEEK: begin
                            if (w_any) begin
                                w_re      = 1'b1;
                                n_ok      = 1'b1;
                                n_use_mem = 1'b1;
                                n_lvl     = 3'(w_top);
                                if (i_cmd.kind == spmf_pkg::K_POP) begin
                                    w_pop   = 1'b1;
                                    n_tot_o = 8'(r_total - TW'(1));
                                    if (w_pv && w_pi == w_top) begin
                                        n_lc_o = 5'(w_pc - CW'(1));
                                    end
                                end
                            end
                        end
                        spmf_pkg::K_BATCH: begin
                            if (w_bn != '0) begin
                                n_done   = 1'b0;
                                n_state  = S_BATCH;
                                n_b_left = 5'(w_bn);
                                n_b_tot  = 8'(w_tot_after);
                                n_b_lc   = w_pv ? 5'(w_lc_after) : 5'd0;
                            end
                        end
                        spmf_pkg::K_CLEAR: begin
                            w_clear = 1'b1;
                            n_ok    = 1'b1;
                            n_tot_o = 8'd0;
                            n_lc_o  = 5'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BATCH: begin
                // one value from the highest non-empty level per cycle
                w_re      = 1'b1;
                w_pop     = 1'b1;
                n_done    = 1'b1;
                n_ok      = 1'b1;
                n_use_mem = 1'b1;
                n_lvl     = 3'(w_top);
                n_tot_o   = r_b_tot;
                n_lc_o    = r_b_lc;
                n_last    = (r_b_left == 5'd1);
                n_b_left  = r_b_left - 5'd1;
                if (r_b_left == 5'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State machine and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_b_left <= 5'd0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_b_left <= n_b_left;
        end
        r_ok      <= n_ok;
        r_use_mem <= n_use_mem;
        r_lvl     <= n_lvl;
        r_last    <= n_last;
        r_tot_o   <= n_tot_o;
        r_lc_o    <= n_lc_o;
        r_b_tot   <= n_b_tot;
        r_b_lc    <= n_b_lc;
    end

    // Per-level pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_total <= '0;
        end else if (w_push) begin
            r_tail[w_pi] <= f_bump(r_tail[w_pi]);
            r_cnt[w_pi]  <= r_cnt[w_pi] + CW'(1);
            r_total      <= r_total + TW'(1);
        end else if (w_pop) begin
            r_head[w_top] <= f_bump(r_head[w_top]);
            r_cnt[w_top]  <= r_cnt[w_top] - CW'(1);
            r_total       <= r_total - TW'(1);
        end
    end

    // Value store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_waddr] <= VALUE_WIDTH'(i_cmd.value);
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Result port
    assign o_done                = r_done;
    assign o_result.ok           = r_ok;
    assign o_result.served_value = r_use_mem ? 32'(r_rd_data) : 32'd0;
    assign o_result.served_level = r_lvl;
    assign o_result.last         = r_last;
    assign o_result.total_count  = r_tot_o;
    assign o_result.level_count  = r_lc_o;

    `SPMF_ASSERT_NOW(a_total_matches, i_clk, i_rst_n, 1'b1, r_total == w_sum)
    `SPMF_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_any)
    `SPMF_ASSERT_NEXT(a_batch_last, i_clk, i_rst_n, (r_state == S_BATCH && r_b_left == 5'd1), (o_done && r_last))

endmodule

FILE: tb/sv/tb_strict_priority_multi_fifo_core.sv
// ----------------------------------------------------------------------------
// Strict priority multi-FIFO core testbench
// Drives push, pop, peek, pop batch and clear requests into the queue and
// keeps a cycle-free copy of the queue contents to predict every result.
// A directed part covers empty-queue service, bad priorities and opcodes,
// value extremes, batch limits and clear. Random traffic follows in phases
// with different request gap rates. Level-filling bursts and long drains
// are mixed in with the random requests.
// ----------------------------------------------------------------------------
module tb_strict_priority_multi_fifo_core;

    localparam int LEVELS         = 4;
    localparam int DEPTH          = 16;
    localparam int VALUE_WIDTH    = 32;
    localparam int BATCH_MAX      = 16;
    localparam int NUM_OPCODES    = 8;
    localparam int NUM_PRIO       = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 32;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    spmf_pkg::t_req    i_req;
    logic              o_done;
    spmf_pkg::t_result o_result;

    // Queue contents as the block should hold them
    logic [31:0] slot_val [LEVELS][DEPTH];
    int          rd_ptr   [LEVELS] = '{default: 0};
    int          wr_ptr   [LEVELS] = '{default: 0};
    int          fill_cnt [LEVELS] = '{default: 0};
    int          held_total = 0;

    // Results still owed by the block, oldest first
    spmf_pkg::t_result pending_results [$];
    spmf_pkg::t_result want;

    int fail_count      = 0;
    int results_checked = 0;
    int full_rejects    = 0;
    int longest_batch   = 0;
    int req_count [NUM_OPCODES] = '{default: 0};
    int unused_ops      = 0;
    int stall_cycles    = 0;

    strict_priority_multi_fifo_core #(
        .LEVELS      (LEVELS),
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .BATCH_MAX   (BATCH_MAX)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Clock, period 10
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Highest level that holds a value, -1 when all are empty
    function automatic int top_level();
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            if (fill_cnt[lv] > 0) return lv;
        end
        return -1;
    endfunction

    // Remove the head value of one level
    function automatic logic [31:0] take_value(int lv);
        logic [31:0] v;
        v = slot_val[lv][rd_ptr[lv]];
        rd_ptr[lv] = (rd_ptr[lv] + 1) % DEPTH;
        fill_cnt[lv]--;
        held_total--;
        return v;
    endfunction

    // Work out the results of one accepted request and queue them
    task automatic predict_request(input spmf_pkg::t_req r);
        spmf_pkg::t_result res [$];
        spmf_pkg::t_result one;
        int                top;
        int                lim;
        logic              pvalid;
        logic [4:0]        lc;
        pvalid = (r.priority_req < LEVELS);
        one = '0;
        one.last = 1'b1;
        case (r.opcode) inside
            spmf_pkg::OP_PUSH: begin
                if (pvalid && fill_cnt[r.priority_req] < DEPTH) begin
                    slot_val[r.priority_req][wr_ptr[r.priority_req]] = r.push_value;
                    wr_ptr[r.priority_req] = (wr_ptr[r.priority_req] + 1) % DEPTH;
                    fill_cnt[r.priority_req]++;
                    held_total++;
                    one.ok = 1'b1;
                end else if (pvalid) begin
                    full_rejects++;
                end
                res.push_back(one);
            end
            spmf_pkg::OP_POP, spmf_pkg::OP_PEEK: begin
                top = top_level();
                if (top >= 0) begin
                    one.ok = 1'b1;
                    one.served_level = 3'(top);
                    if (r.opcode == spmf_pkg::OP_POP) one.served_value = take_value(top);
                    else one.served_value = slot_val[top][rd_ptr[top]];
                end
                res.push_back(one);
            end
            spmf_pkg::OP_BATCH: begin
                lim = (r.batch_count > BATCH_MAX) ? BATCH_MAX : int'(r.batch_count);
                while (res.size() < lim && top_level() >= 0) begin
                    top = top_level();
                    one = '0;
                    one.ok = 1'b1;
                    one.served_level = 3'(top);
                    one.served_value = take_value(top);
                    res.push_back(one);
                end
                if (res.size() > longest_batch) longest_batch = res.size();
                if (res.size() == 0) begin
                    one = '0;
                    one.last = 1'b1;
                    res.push_back(one);
                end else begin
                    res[res.size() - 1].last = 1'b1;
                end
            end
            spmf_pkg::OP_CLEAR: begin
                rd_ptr = '{default: 0};
                wr_ptr = '{default: 0};
                fill_cnt = '{default: 0};
                held_total = 0;
                one.ok = 1'b1;
                res.push_back(one);
            end
            default: begin
                res.push_back(one);
            end
        endcase
        // counts are reported after the whole request
        lc = pvalid ? 5'(fill_cnt[r.priority_req]) : 5'd0;
        foreach (res[k]) begin
            res[k].total_count = 8'(held_total);
            res[k].level_count = lc;
            pending_results.push_back(res[k]);
        end
    endtask

    function automatic spmf_pkg::t_req random_request();
        spmf_pkg::t_req r;
        r.opcode       = 3'($urandom_range(NUM_OPCODES - 1));
        r.priority_req = 3'($urandom_range(NUM_PRIO - 1));
        r.push_value   = $urandom;
        r.batch_count  = 5'($urandom_range(31));
        return r;
    endfunction

    function automatic spmf_pkg::t_req make_req(logic [2:0] op, logic [2:0] pr,
                                                logic [31:0] val, logic [4:0] bc);
        spmf_pkg::t_req r;
        r.opcode       = op;
        r.priority_req = pr;
        r.push_value   = val;
        r.batch_count  = bc;
        return r;
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input spmf_pkg::t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_request(r);
        req_count[r.opcode]++;
    endtask

    // Idle cycles before a request, each with the given chance in a hundred
    task automatic idle_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Result checker: every strobe must match the oldest pending result
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending, expected none, got %p",
                         $time, o_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("ok", want.ok, o_result.ok);
                check_field("served_value", want.served_value, o_result.served_value);
                check_field("served_level", want.served_level, o_result.served_level);
                check_field("last", want.last, o_result.last);
                check_field("total_count", want.total_count, o_result.total_count);
                check_field("level_count", want.level_count, o_result.level_count);
            end
        end
    end

    // Watchdog: too long with no request taken and no result given
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no activity for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[strict_priority_multi_fifo_core] ERROR");
                $finish;
            end
        end
    end

    // Service requests on an empty queue
    task automatic test_empty_queue();
        send_request(make_req(spmf_pkg::OP_POP, 3'($urandom_range(7)), $urandom, 5'd3));
        send_request(make_req(spmf_pkg::OP_PEEK, 3'd2, $urandom, 5'd16));
        send_request(make_req(spmf_pkg::OP_BATCH, 3'd0, $urandom, 5'd5));
        send_request(make_req(spmf_pkg::OP_BATCH, 3'd6, $urandom, 5'd0));
    endtask

    // Pushes to levels that do not exist, and unused opcodes
    task automatic test_bad_requests();
        send_request(make_req(spmf_pkg::OP_PUSH, 3'(LEVELS), 32'hFFFF_FFFF, 5'd31));
        send_request(make_req(spmf_pkg::OP_PUSH, 3'(NUM_PRIO - 1), 32'h0, 5'd0));
        for (int op = spmf_pkg::OP_CLEAR + 1; op < NUM_OPCODES; op++) begin
            send_request(make_req(3'(op), 3'($urandom_range(7)), $urandom, 5'($urandom)));
        end
    endtask

    // Value extremes at the lowest and highest levels, a pattern at level 1, then peek and pop
    task automatic test_push_extremes();
        send_request(make_req(spmf_pkg::OP_PUSH, 3'd0, 32'h0, 5'd0));
        send_request(make_req(spmf_pkg::OP_PUSH, 3'(LEVELS - 1), 32'hFFFF_FFFF, 5'd31));
        send_request(make_req(spmf_pkg::OP_PUSH, 3'd1, 32'hA5A5_5A5A, 5'd16));
        send_request(make_req(spmf_pkg::OP_PUSH, 3'(LEVELS - 1), 32'h0000_0001, 5'd1));
        send_request(make_req(spmf_pkg::OP_PEEK, 3'(LEVELS - 1), $urandom, 5'd2));
        send_request(make_req(spmf_pkg::OP_POP, 3'd0, $urandom, 5'd9));
    endtask

    // Zero-length batch on a non-empty queue, single batch, capped batch
    task automatic test_batch_limits();
        send_request(make_req(spmf_pkg::OP_BATCH, 3'd1, $urandom, 5'd0));
        send_request(make_req(spmf_pkg::OP_BATCH, 3'd1, $urandom, 5'd1));
        send_request(make_req(spmf_pkg::OP_BATCH, 3'd0, $urandom, 5'd31));
    endtask

    // Clear drops everything that is held
    task automatic test_clear();
        send_request(make_req(spmf_pkg::OP_PUSH, 3'd2, $urandom, 5'($urandom)));
        send_request(make_req(spmf_pkg::OP_PUSH, 3'd0, $urandom, 5'($urandom)));
        send_request(make_req(spmf_pkg::OP_CLEAR, 3'd2, $urandom, 5'($urandom)));
        send_request(make_req(spmf_pkg::OP_POP, 3'd0, $urandom, 5'($urandom)));
    endtask

    // Random traffic: mostly single requests, plus level fills and drains
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int             sent;
        int             pick;
        int             lv;
        bit             back_to_back;
        spmf_pkg::t_req r;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                // fill one level one past its depth
                lv = $urandom_range(LEVELS - 1);
                back_to_back = $urandom_range(1);
                repeat (DEPTH - fill_cnt[lv] + 1) begin
                    r = random_request();
                    r.opcode = spmf_pkg::OP_PUSH;
                    r.priority_req = 3'(lv);
                    if (!back_to_back) idle_gap(idle_pct);
                    send_request(r);
                    sent++;
                end
            end else if (pick < 14) begin
                // long drain, often across levels
                r = random_request();
                r.opcode = spmf_pkg::OP_BATCH;
                r.batch_count = 5'($urandom_range(31, BATCH_MAX));
                idle_gap(idle_pct);
                send_request(r);
                sent++;
            end else begin
                r = random_request();
                pick = $urandom_range(99);
                if (pick < 45) begin
                    r.opcode = spmf_pkg::OP_PUSH;
                    if ($urandom_range(99) < 85) r.priority_req = 3'($urandom_range(LEVELS - 1));
                    else r.priority_req = 3'($urandom_range(NUM_PRIO - 1, LEVELS));
                end else if (pick < 60) begin
                    r.opcode = spmf_pkg::OP_POP;
                end else if (pick < 70) begin
                    r.opcode = spmf_pkg::OP_PEEK;
                end else if (pick < 84) begin
                    r.opcode = spmf_pkg::OP_BATCH;
                end else if (pick < 87) begin
                    r.opcode = spmf_pkg::OP_CLEAR;
                end else begin
                    r.opcode = 3'($urandom_range(NUM_OPCODES - 1, spmf_pkg::OP_CLEAR + 1));
                end
                idle_gap(idle_pct);
                send_request(r);
                sent++;
            end
        end
    endtask

    // Test sequence
    initial begin
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_bad_requests();
        test_push_extremes();
        test_batch_limits();
        test_clear();
        test_random_traffic(0, 45);
        test_random_traffic(80, 50);
        test_random_traffic(0, 45);
        test_random_traffic(21, 50);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        for (int op = spmf_pkg::OP_CLEAR + 1; op < NUM_OPCODES; op++) begin
            unused_ops += req_count[op];
        end
        $display("covered %0d push, %0d pop, %0d peek, %0d batch, %0d clear, %0d unused-opcode",
                 req_count[spmf_pkg::OP_PUSH], req_count[spmf_pkg::OP_POP],
                 req_count[spmf_pkg::OP_PEEK], req_count[spmf_pkg::OP_BATCH],
                 req_count[spmf_pkg::OP_CLEAR], unused_ops);
        $display("%0d full-level rejects, longest batch %0d, %0d results checked",
                 full_rejects, longest_batch, results_checked);
        if (fail_count == 0) begin
            $display("[strict_priority_multi_fifo_core] OK");
        end else begin
            $display("[strict_priority_multi_fifo_core] ERROR");
        end
        $finish;
    end

endmodule
